### design/dq_pkg.sv
`default_nettype none
package dq_pkg;

   // Queue geometry.
   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W    = $clog2(DEPTH + 1);
   localparam int OP_W       = 3;
   localparam int STATUS_W   = 2;

   localparam logic [COUNT_W-1:0] DEPTH_COUNT = COUNT_W'(DEPTH);
   localparam logic [ADDR_W-1:0]  LAST_ADDR   = ADDR_W'(DEPTH - 1);
   localparam logic [ADDR_W:0]    DEPTH_SUM   = (ADDR_W + 1)'(DEPTH);

   // Operation codes.
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
   localparam logic [OP_W-1:0] OP_PEEK_BACK  = 3'd5;
   localparam logic [OP_W-1:0] OP_CLEAR      = 3'd6;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DATA  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                push_front;
      logic                push_back;
      logic                read_front;
      logic                read_back;
      logic                drop_front;
      logic                drop_back;
      logic                clear;
      logic                load_rsp;
      logic [STATUS_W-1:0] rsp_code;
      logic                capture;
   } dq_cmd_type;

   // Occupancy flags from the datapath to the controller.
   typedef struct packed {
      logic empty;
      logic full;
   } dq_status_type;

endpackage
`default_nettype wire

### design/dq_if.sv
`default_nettype none
// Request channel: one queue operation per transfer.
interface dq_req_if;
   logic                              valid;
   logic                              ready;
   logic [dq_pkg::OP_W-1:0]           op;
   logic [dq_pkg::DATA_WIDTH-1:0]     value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

// Response channel: one result per operation.
interface dq_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [dq_pkg::STATUS_W-1:0]       status;
   logic [dq_pkg::DATA_WIDTH-1:0]     data;

   modport source (output valid, output status, output data, input ready);
   modport sink   (input valid, input status, input data, output ready);
endinterface
`default_nettype wire

### design/dq_ram.sv
`default_nettype none
// Simple dual-port RAM: one write port, one read port with registered data.
module dq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

### design/dq_ctrl.sv
`default_nettype none
// Controller: decodes each operation, sequences the entry read and owns
// the response valid flag.
module dq_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [dq_pkg::OP_W-1:0]       req_op,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire dq_pkg::dq_status_type         status,
   output dq_pkg::dq_cmd_type                 cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   // A request is taken when idle and the response register is free or drains.
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Operation decode into datapath commands.
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      if (state_ff == ST_READ) begin
         cmd.capture = 1'b1;
         state_in    = ST_IDLE;
      end else if (accept) begin
         case (req_op)
            dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
               cmd.load_rsp = 1'b1;
               if (status.full) begin
                  cmd.rsp_code = dq_pkg::STATUS_FULL;
               end else begin
                  cmd.rsp_code   = dq_pkg::STATUS_OK;
                  cmd.push_front = (req_op == dq_pkg::OP_PUSH_FRONT);
                  cmd.push_back  = (req_op == dq_pkg::OP_PUSH_BACK);
               end
            end
            dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK,
            dq_pkg::OP_PEEK_FRONT, dq_pkg::OP_PEEK_BACK: begin
               cmd.load_rsp = 1'b1;
               if (status.empty) begin
                  cmd.rsp_code = dq_pkg::STATUS_EMPTY;
               end else begin
                  cmd.rsp_code   = dq_pkg::STATUS_DATA;
                  cmd.read_front = req_op inside {dq_pkg::OP_POP_FRONT,
                                                  dq_pkg::OP_PEEK_FRONT};
                  cmd.read_back  = req_op inside {dq_pkg::OP_POP_BACK,
                                                  dq_pkg::OP_PEEK_BACK};
                  cmd.drop_front = (req_op == dq_pkg::OP_POP_FRONT);
                  cmd.drop_back  = (req_op == dq_pkg::OP_POP_BACK);
                  state_in       = ST_READ;
               end
            end
            dq_pkg::OP_CLEAR: begin
               cmd.load_rsp = 1'b1;
               cmd.rsp_code = dq_pkg::STATUS_OK;
               cmd.clear    = 1'b1;
            end
            default: begin
               cmd.load_rsp = 1'b1;
               cmd.rsp_code = dq_pkg::STATUS_OK;
            end
         endcase
      end
   end

   // Response becomes valid once its data is complete; it clears on transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.capture || (accept && state_in == ST_IDLE)) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

### design/dq_datapath.sv
`default_nettype none
// Datapath: ring pointers, entry RAM and the response register.
module dq_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire dq_pkg::dq_cmd_type                cmd,
   output dq_pkg::dq_status_type                  status,
   input  wire logic [dq_pkg::DATA_WIDTH-1:0]     req_value,
   output logic      [dq_pkg::STATUS_W-1:0]       rsp_status,
   output logic      [dq_pkg::DATA_WIDTH-1:0]     rsp_data
);

   logic [dq_pkg::ADDR_W-1:0]     head_ff, head_in;
   logic [dq_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic [dq_pkg::STATUS_W-1:0]   rsp_status_ff;
   logic [dq_pkg::DATA_WIDTH-1:0] rsp_data_ff;

   logic [dq_pkg::ADDR_W-1:0]     head_dec;
   logic [dq_pkg::ADDR_W-1:0]     head_inc;
   logic [dq_pkg::ADDR_W-1:0]     back_offset;
   logic [dq_pkg::ADDR_W:0]       back_sum;
   logic [dq_pkg::ADDR_W-1:0]     back_addr;
   logic [dq_pkg::ADDR_W-1:0]     wr_addr;
   logic [dq_pkg::ADDR_W-1:0]     rd_addr;
   logic [dq_pkg::DATA_WIDTH-1:0] rd_data;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == dq_pkg::DEPTH_COUNT);

   // Neighbor positions of the head with wrap at the ring end.
   assign head_dec = (head_ff == '0) ? dq_pkg::LAST_ADDR : head_ff - 1'b1;
   assign head_inc = (head_ff == dq_pkg::LAST_ADDR) ? '0 : head_ff + 1'b1;

   // Back position: one past the last entry for a push, the last entry otherwise.
   assign back_offset = cmd.push_back ? count_ff[dq_pkg::ADDR_W-1:0]
                                      : dq_pkg::ADDR_W'(count_ff - 1'b1);
   assign back_sum    = {1'b0, head_ff} + {1'b0, back_offset};
   assign back_addr   = (back_sum >= dq_pkg::DEPTH_SUM)
                        ? dq_pkg::ADDR_W'(back_sum - dq_pkg::DEPTH_SUM)
                        : back_sum[dq_pkg::ADDR_W-1:0];

   assign wr_addr = cmd.push_front ? head_dec : back_addr;
   assign rd_addr = cmd.read_front ? head_ff : back_addr;

   dq_ram #(
      .WIDTH (dq_pkg::DATA_WIDTH),
      .DEPTH (dq_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.push_front || cmd.push_back),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (cmd.read_front || cmd.read_back),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Pointer and count update.
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.clear) begin
         head_in  = '0;
         count_in = '0;
      end else if (cmd.push_front) begin
         head_in  = head_dec;
         count_in = count_ff + 1'b1;
      end else if (cmd.push_back) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.drop_front) begin
         head_in  = head_inc;
         count_in = count_ff - 1'b1;
      end else if (cmd.drop_back) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // Response register: status at decode, read data in the cycle after.
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff <= cmd.rsp_code;
         rsp_data_ff   <= '0;
      end else if (cmd.capture) begin
         rsp_data_ff   <= rd_data;
      end
   end

   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;

endmodule
`default_nettype wire

### design/double_ended_queue_top.sv
`default_nettype none
// Bounded double-ended queue on a ring buffer in a registered-read RAM.
// Push, clear and error results are valid in the cycle after the transfer;
// pop and peek data pass the RAM read register, then the response register.
// Push, clear and errors may run back to back while responses are taken; pop
// and peek hold off the next request until the read completes. Synchronous reset
// empties the queue (head and count to zero); stored words are left as they are.
module double_ended_queue_top (
   input wire logic clock,
   input wire logic reset,
   dq_req_if.sink   req_ch,
   dq_rsp_if.source rsp_ch
);

   dq_pkg::dq_cmd_type    cmd;
   dq_pkg::dq_status_type status;

   // Operation sequencing.
   dq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_op    (req_ch.op),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Storage, pointers and response register.
   dq_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_value  (req_ch.value),
      .rsp_status (rsp_ch.status),
      .rsp_data   (rsp_ch.data)
   );

endmodule
`default_nettype wire

### dv/dq_checker.sv
`timescale 1ns / 1ps
// Watches both channels of the deque, keeps its own copy of the ring buffer,
// and checks every response against the oldest outstanding prediction.
module dq_checker (
   input  wire logic clock,
   input  wire logic reset,
   dq_req_if         req_mon,
   dq_rsp_if         rsp_mon,
   output int        fail_count,
   output int        pending
);

   typedef logic [dq_pkg::DATA_WIDTH-1:0] word_type;
   typedef logic [dq_pkg::ADDR_W-1:0]     slot_type;
   typedef logic [dq_pkg::COUNT_W-1:0]    count_type;

   typedef struct packed {
      logic [dq_pkg::STATUS_W-1:0] status;
      word_type                    data;
   } deque_result_type;

   // Shadow copy of the queue contents and pointers.
   word_type  model_words [dq_pkg::DEPTH];
   slot_type  model_head;
   count_type model_count;

   // Results owed by the block, oldest first.
   deque_result_type due_results [$];
   int               results_checked;

   function automatic slot_type ring_slot(int offset);
      return slot_type'((int'(model_head) + offset) % dq_pkg::DEPTH);
   endfunction

   // Applies one operation to the shadow queue and returns the response it owes.
   function automatic deque_result_type deque_apply(logic [dq_pkg::OP_W-1:0] op,
                                                    word_type value);
      deque_result_type res;
      slot_type         slot;
      res.status = dq_pkg::STATUS_OK;
      res.data   = '0;
      case (op)
         dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
            if (model_count == dq_pkg::DEPTH_COUNT) begin
               res.status = dq_pkg::STATUS_FULL;
            end else begin
               if (op == dq_pkg::OP_PUSH_FRONT) begin
                  model_head = ring_slot(dq_pkg::DEPTH - 1);
                  slot       = model_head;
               end else begin
                  slot = ring_slot(int'(model_count));
               end
               model_words[slot] = value;
               model_count       = model_count + 1'b1;
            end
         end
         dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK,
         dq_pkg::OP_PEEK_FRONT, dq_pkg::OP_PEEK_BACK: begin
            if (model_count == '0) begin
               res.status = dq_pkg::STATUS_EMPTY;
            end else begin
               if (op inside {dq_pkg::OP_POP_FRONT, dq_pkg::OP_PEEK_FRONT}) begin
                  slot = model_head;
               end else begin
                  slot = ring_slot(int'(model_count) - 1);
               end
               res.status = dq_pkg::STATUS_DATA;
               res.data   = model_words[slot];
               if (op == dq_pkg::OP_POP_FRONT) begin
                  model_head  = ring_slot(1);
                  model_count = model_count - 1'b1;
               end else if (op == dq_pkg::OP_POP_BACK) begin
                  model_count = model_count - 1'b1;
               end
            end
         end
         dq_pkg::OP_CLEAR: begin
            model_head  = '0;
            model_count = '0;
         end
         default: begin
            // An unassigned code leaves the queue alone.
         end
      endcase
      return res;
   endfunction

   // Prints one line per mismatch and counts every one.
   task automatic report_mismatch(string what);
      $display("[%0t] mismatch on response %0d: %s", $time, results_checked, what);
      fail_count = fail_count + 1;
   endtask

   // Responses are checked before the request of the same edge is predicted;
   // the block never answers in the cycle of the request transfer.
   always @(posedge clock) begin : watch
      deque_result_type want;
      if (reset) begin
         model_head      = '0;
         model_count     = '0;
         results_checked = 0;
         fail_count      = 0;
         due_results.delete();
         pending <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_results.size() == 0) begin
               report_mismatch("response with no operation outstanding");
            end else begin
               want = due_results.pop_front();
               if (rsp_mon.status !== want.status) begin
                  report_mismatch($sformatf("status %0d, predicted %0d",
                                            rsp_mon.status, want.status));
               end
               if (rsp_mon.data !== want.data) begin
                  report_mismatch($sformatf("data %h, predicted %h",
                                            rsp_mon.data, want.data));
               end
            end
            results_checked++;
         end
         if (req_mon.valid && req_mon.ready) begin
            due_results.push_back(deque_apply(req_mon.op, req_mon.value));
         end
         pending <= due_results.size();
      end
   end

endmodule

### dv/tb_double_ended_queue_top.sv
`timescale 1ns / 1ps
module tb_double_ended_queue_top;

   typedef logic [dq_pkg::DATA_WIDTH-1:0] word_type;
   typedef logic [dq_pkg::OP_W-1:0]       op_type;

   // Code with no operation assigned to it.
   localparam op_type OP_UNUSED = 3'd7;

   localparam int LIMIT_CYCLES  = 200000;
   localparam int RANDOM_ITEMS  = 900;
   localparam int SEGMENT_ITEMS = 30;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count   = 0;
   int   hold_requests = 0;
   int   holds_served  = 0;
   int   fail_count;
   int   pending;

   dq_req_if req_ch ();
   dq_rsp_if rsp_ch ();

   double_ended_queue_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   dq_checker queue_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Watchdog for a hung run.
   initial begin
      wait (cycle_count >= LIMIT_CYCLES);
      $display("FAIL");
      $finish;
   end

   // Offers one operation and returns at the edge where the transfer happens.
   task automatic send_op(input op_type op, input word_type value);
      req_ch.valid <= 1'b1;
      req_ch.op    <= op;
      req_ch.value <= value;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Data words lean toward all zeros, all ones and walking bits.
   function automatic word_type pick_word();
      int k;
      k = $urandom_range(0, dq_pkg::DATA_WIDTH - 1);
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return word_type'(1) << k;
         3:       return ~(word_type'(1) << k);
         default: return word_type'($urandom());
      endcase
   endfunction

   // Stretches of always-ready, random, mostly-stalled and mostly-ready response
   // acceptance, plus long hold-offs on request so the queue backs up.
   initial begin
      int mode;
      int span;
      rsp_ch.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (holds_served < hold_requests) begin
            holds_served++;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 120);
            repeat (span) begin
               case (mode)
                  0:       rsp_ch.ready <= 1'b1;
                  1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                  2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                  default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // Request side and verdict.
   initial begin
      op_type op;
      int     push_pct;
      int     burst_left;
      int     gap;
      int     sent;
      int     pick;
      req_ch.valid = 1'b0;
      req_ch.op    = dq_pkg::OP_CLEAR;
      req_ch.value = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reads on an empty queue must all report empty.
      send_op(dq_pkg::OP_POP_FRONT,  word_type'($urandom()));
      send_op(dq_pkg::OP_POP_BACK,   word_type'($urandom()));
      send_op(dq_pkg::OP_PEEK_FRONT, word_type'($urandom()));
      send_op(dq_pkg::OP_PEEK_BACK,  word_type'($urandom()));
      // Extreme words at both ends; the front push wraps the head below zero.
      send_op(dq_pkg::OP_PUSH_FRONT, '0);
      send_op(dq_pkg::OP_PUSH_BACK,  '1);
      send_op(dq_pkg::OP_PEEK_FRONT, word_type'($urandom()));
      send_op(dq_pkg::OP_PEEK_BACK,  word_type'($urandom()));
      send_op(OP_UNUSED,             word_type'($urandom()));
      // Fill to capacity, then pushes at either end must be refused.
      for (int i = 0; i < dq_pkg::DEPTH - 2; i++) begin
         send_op((i % 2 == 0) ? dq_pkg::OP_PUSH_BACK : dq_pkg::OP_PUSH_FRONT,
                 pick_word());
      end
      send_op(dq_pkg::OP_PUSH_BACK,  pick_word());
      send_op(dq_pkg::OP_PUSH_FRONT, pick_word());
      send_op(dq_pkg::OP_CLEAR,      word_type'($urandom()));

      // Random traffic in segments that favor filling, draining or a mix.
      hold_requests = 1;
      sent          = 0;
      push_pct      = 50;
      burst_left    = $urandom_range(0, 20);
      while (sent < RANDOM_ITEMS) begin
         if (sent % SEGMENT_ITEMS == 0) begin
            case ($urandom_range(0, 4))
               0:       push_pct = 85;
               1:       push_pct = 70;
               2:       push_pct = 50;
               3:       push_pct = 30;
               default: push_pct = 15;
            endcase
         end
         if (sent == RANDOM_ITEMS / 2) begin
            hold_requests = 2;
         end

         pick = $urandom_range(0, 99);
         if (pick == 0) begin
            op = OP_UNUSED;
         end else if (pick < 3) begin
            op = dq_pkg::OP_CLEAR;
         end else if ($urandom_range(0, 99) < push_pct) begin
            op = ($urandom_range(0, 1) == 1) ? dq_pkg::OP_PUSH_FRONT
                                             : dq_pkg::OP_PUSH_BACK;
         end else begin
            case ($urandom_range(0, 3))
               0:       op = dq_pkg::OP_POP_FRONT;
               1:       op = dq_pkg::OP_POP_BACK;
               2:       op = dq_pkg::OP_PEEK_FRONT;
               default: op = dq_pkg::OP_PEEK_BACK;
            endcase
         end
         send_op(op, pick_word());
         sent++;

         // Idle between bursts; some bursts run straight into the next one.
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(0, 20);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
               req_ch.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
      req_ch.valid <= 1'b0;

      // Drain every outstanding response, then watch for strays.
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
